[rtl/ptf_pkg.sv]
// Package with the shared types and constants of the pan/tilt target follower.
`timescale 1ns / 1ps
`default_nettype none
package ptf_pkg;

    localparam int SumW     = 36;
    localparam int WgtW     = 20;
    localparam int PosW     = 16;
    localparam int AreaW    = 20;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 20;
    localparam int DivCntW  = 6;

    localparam logic [33:0] LockSq = 34'd1717987;

    localparam logic [PosW-1:0]  PanMinRst  = 16'd6554;
    localparam logic [PosW-1:0]  PanMaxRst  = 16'd58982;
    localparam logic [PosW-1:0]  TiltMinRst = 16'd6554;
    localparam logic [PosW-1:0]  TiltMaxRst = 16'd58982;
    localparam logic [PosW-1:0]  TargXRst   = 16'd32768;
    localparam logic [PosW-1:0]  TargYRst   = 16'd28180;
    localparam logic [PosW-1:0]  GainRst    = 16'd2621;
    localparam logic [AreaW-1:0] AreaMinRst = 20'd32;
    localparam logic [PosW-1:0]  CentrePos  = 16'd32768;

    typedef enum logic [1:0] {
        ST_MOVED  = 2'd0,
        ST_LOCKED = 2'd1,
        ST_LOST   = 2'd2
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PAN_MIN   = 3'd0,
        CFG_PAN_MAX   = 3'd1,
        CFG_TILT_MIN  = 3'd2,
        CFG_TILT_MAX  = 3'd3,
        CFG_TARGET_X  = 3'd4,
        CFG_TARGET_Y  = 3'd5,
        CFG_STEP_GAIN = 3'd6,
        CFG_AREA_MIN  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [PosW-1:0]  pan_min;
        logic [PosW-1:0]  pan_max;
        logic [PosW-1:0]  tilt_min;
        logic [PosW-1:0]  tilt_max;
        logic [PosW-1:0]  target_x;
        logic [PosW-1:0]  target_y;
        logic [PosW-1:0]  step_gain;
        logic [AreaW-1:0] area_min;
    } t_cfg;

    typedef struct packed {
        logic [SumW-1:0] sum_x;
        logic [SumW-1:0] sum_y;
        logic [WgtW-1:0] weight;
        logic            no_blob;
        logic            lost;
    } t_item;

    typedef struct packed {
        logic [PosW-1:0] pan;
        logic [PosW-1:0] tilt;
        logic            laser;
        t_status         status;
    } t_result;

    typedef struct packed {
        logic            start;
        logic [SumW-1:0] dividend;
        logic [WgtW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [SumW-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIVX,
        BK_DIVY,
        BK_SQX,
        BK_SQY,
        BK_PANM,
        BK_PAN,
        BK_DIVR,
        BK_HALF,
        BK_TILTM,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

[rtl/ptf_front.sv]
// Front end: accepts frame items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module ptf_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    output logic                       o_full,
    input  wire  [ptf_pkg::SumW-1:0]   i_sum_x,
    input  wire  [ptf_pkg::SumW-1:0]   i_sum_y,
    input  wire  [ptf_pkg::WgtW-1:0]   i_pixel_weight,
    input  wire  [ptf_pkg::AreaW-1:0]  i_blob_area,
    input  wire  [ptf_pkg::AreaW-1:0]  i_area_min,
    output logic                       o_valid,
    output ptf_pkg::t_item             o_item,
    input  wire                        i_take
);
    import ptf_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    t_item       n_item;
    logic        wr_en;
    logic        rd_en;

    always_comb begin
        n_item.sum_x   = i_sum_x;
        n_item.sum_y   = i_sum_y;
        n_item.weight  = i_pixel_weight;
        n_item.no_blob = (i_pixel_weight == '0);
        n_item.lost    = (i_blob_area <= i_area_min);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule
`default_nettype wire

[rtl/ptf_div.sv]
// Radix-2 restoring divider shared by the centroid and tilt-window divisions.
`timescale 1ns / 1ps
`default_nettype none
module ptf_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ptf_pkg::t_div_req  i_req,
    output ptf_pkg::t_div_rsp  o_rsp
);
    import ptf_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DivCntW-1:0] r_cnt;
    logic [WgtW-1:0]    r_rem;
    logic [SumW-1:0]    r_quo;
    logic [WgtW-1:0]    r_dsr;
    logic [WgtW:0]      rem_sh;
    logic [WgtW:0]      diff;
    logic               ge;

    assign rem_sh = {r_rem, r_quo[SumW-1]};
    assign diff   = rem_sh - {1'b0, r_dsr};
    assign ge     = (rem_sh >= {1'b0, r_dsr});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WgtW-1:0] : rem_sh[WgtW-1:0];
            r_quo <= {r_quo[SumW-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == DivCntW'(SumW - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == DivCntW'(SumW - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/ptf_back.sv]
// Back end: centroid, lock test, pan and tilt update, and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module ptf_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ptf_pkg::t_cfg         i_cfg,
    input  wire                   i_valid,
    input  ptf_pkg::t_item        i_item,
    output logic                  o_take,
    output ptf_pkg::t_div_req     o_div_req,
    input  ptf_pkg::t_div_rsp     i_div_rsp,
    output logic                  o_empty,
    input  wire                   i_pop,
    output ptf_pkg::t_result      o_result
);
    import ptf_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    t_item              r_item;
    logic [PosW-1:0]    r_cx;
    logic [PosW-1:0]    r_cy;
    logic [33:0]        r_acc;
    logic signed [34:0] r_prod;
    logic [PosW-1:0]    r_pan;
    logic [PosW-1:0]    r_amp;
    logic signed [34:0] r_half;
    logic signed [19:0] r_hi;
    logic signed [19:0] r_lo;
    t_status            r_status;
    logic [PosW-1:0]    r_pan_now;
    logic [PosW-1:0]    r_tilt_now;
    logic               r_laser;

    t_result            r_oq [2];
    logic               r_owp;
    logic               r_orp;
    logic [1:0]         r_ocnt;
    logic               oq_push;
    t_result            n_result;

    logic [PosW-1:0]    cent;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] sq;
    logic [33:0]        sq_sum;
    logic signed [16:0] gain_s;
    logic signed [34:0] step_full;
    logic signed [18:0] step;
    logic signed [20:0] pan_raw;
    logic signed [20:0] pan_c;
    logic signed [16:0] den;
    logic [15:0]        pan_off;
    logic signed [17:0] r_cent;
    logic [16:0]        r_abs;
    logic [16:0]        amp_w;
    logic signed [16:0] tdiff;
    logic [32:0]        mid;
    logic signed [35:0] hi_full;
    logic signed [35:0] lo_full;
    logic signed [20:0] tilt_raw;
    logic signed [20:0] tilt_c;
    logic               lock_hit;

    assign cent = (i_div_rsp.quotient[SumW-1:PosW] != '0) ? '1
                : i_div_rsp.quotient[PosW-1:0];

    assign gain_s    = $signed({1'b0, i_cfg.step_gain});
    assign dx        = $signed({1'b0, i_cfg.target_x}) - $signed({1'b0, r_cx});
    assign dy        = $signed({1'b0, i_cfg.target_y}) - $signed({1'b0, r_cy});
    assign sq        = (r_state == BK_SQX) ? dx * dx : dy * dy;
    assign sq_sum    = r_acc + 34'(unsigned'(sq));
    assign lock_hit  = (sq_sum < LockSq);
    assign step_full = r_prod + 35'sd32768;
    assign step      = step_full[34:16];

    always_comb begin
        pan_raw = $signed({5'b0, r_pan_now}) - 21'(step);
        pan_c   = pan_raw;
        if (pan_c > $signed({5'b0, i_cfg.pan_max})) begin
            pan_c = $signed({5'b0, i_cfg.pan_max});
        end
        if (pan_c < $signed({5'b0, i_cfg.pan_min})) begin
            pan_c = $signed({5'b0, i_cfg.pan_min});
        end
    end

    assign den     = $signed({1'b0, i_cfg.pan_max}) - $signed({1'b0, i_cfg.pan_min});
    assign pan_off = pan_c[15:0] - i_cfg.pan_min;

    assign r_cent = $signed({1'b0, i_div_rsp.quotient[16:0]}) - 18'sd32768;
    assign r_abs  = r_cent[17] ? 17'(-r_cent) : 17'(r_cent);
    assign amp_w  = 17'd32768 - r_abs;

    assign tdiff   = $signed({1'b0, i_cfg.tilt_max}) - $signed({1'b0, i_cfg.tilt_min});
    assign mid     = 33'({1'b0, i_cfg.tilt_min} + {1'b0, i_cfg.tilt_max}) << 15;
    assign hi_full = $signed({3'b0, mid}) + 36'(r_half) + 36'sd32768;
    assign lo_full = $signed({3'b0, mid}) - 36'(r_half) + 36'sd32768;

    always_comb begin
        tilt_raw = $signed({5'b0, r_tilt_now}) + 21'(step);
        tilt_c   = tilt_raw;
        if (tilt_c > 21'(r_hi)) begin
            tilt_c = 21'(r_hi);
        end
        if (tilt_c < 21'(r_lo)) begin
            tilt_c = 21'(r_lo);
        end
        if (tilt_c > 21'sd65535) begin
            tilt_c = 21'sd65535;
        end
        if (tilt_c < 21'sd0) begin
            tilt_c = 21'sd0;
        end
    end

    always_comb begin
        n_result.status = r_status;
        if (r_status == ST_MOVED) begin
            n_result.pan   = r_pan;
            n_result.tilt  = tilt_c[15:0];
            n_result.laser = 1'b0;
        end else if (r_status == ST_LOCKED) begin
            n_result.pan   = r_pan_now;
            n_result.tilt  = r_tilt_now;
            n_result.laser = ~r_laser;
        end else begin
            n_result.pan   = r_pan_now;
            n_result.tilt  = r_tilt_now;
            n_result.laser = r_laser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        o_take             = 1'b0;
        oq_push            = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_item.sum_x;
        o_div_req.divisor  = i_item.weight;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_take          = 1'b1;
                    o_div_req.start = 1'b1;
                    n_state         = BK_DIVX;
                end
            end
            BK_DIVX: begin
                if (i_div_rsp.done) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = r_item.sum_y;
                    o_div_req.divisor  = r_item.weight;
                    n_state            = BK_DIVY;
                end
            end
            BK_DIVY: begin
                if (i_div_rsp.done) begin
                    n_state = r_item.lost ? BK_DONE : BK_SQX;
                end
            end
            BK_SQX: begin
                n_state = BK_SQY;
            end
            BK_SQY: begin
                n_state = lock_hit ? BK_DONE : BK_PANM;
            end
            BK_PANM: begin
                n_state = BK_PAN;
            end
            BK_PAN: begin
                if (den > 17'sd0) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {4'b0, pan_off, 16'b0};
                    o_div_req.divisor  = {4'b0, den[15:0]};
                    n_state            = BK_DIVR;
                end else begin
                    n_state = BK_HALF;
                end
            end
            BK_DIVR: begin
                if (i_div_rsp.done) begin
                    n_state = BK_HALF;
                end
            end
            BK_HALF: begin
                n_state = BK_TILTM;
            end
            BK_TILTM: begin
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (r_ocnt != 2'd2) begin
                    oq_push = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
        end
        if (r_state == BK_DIVX && i_div_rsp.done) begin
            r_cx <= r_item.no_blob ? '0 : cent;
        end
        if (r_state == BK_DIVY && i_div_rsp.done) begin
            r_cy     <= r_item.no_blob ? '0 : cent;
            r_status <= ST_LOST;
        end
        if (r_state == BK_SQX) begin
            r_acc <= 34'(unsigned'(sq));
        end
        if (r_state == BK_SQY) begin
            r_status <= lock_hit ? ST_LOCKED : ST_MOVED;
        end
        if (r_state == BK_PANM) begin
            r_prod <= 35'(dx) * 35'(gain_s);
        end
        if (r_state == BK_PAN) begin
            r_pan <= pan_c[15:0];
            r_amp <= '0;
        end
        if (r_state == BK_DIVR && i_div_rsp.done) begin
            r_amp <= amp_w[15:0];
        end
        if (r_state == BK_HALF) begin
            r_half <= 35'(tdiff) * 35'($signed({1'b0, r_amp}));
        end
        if (r_state == BK_TILTM) begin
            r_hi   <= hi_full[35:16];
            r_lo   <= lo_full[35:16];
            r_prod <= 35'(dy) * 35'(gain_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_now  <= CentrePos;
            r_tilt_now <= CentrePos;
            r_laser    <= 1'b0;
        end else if (oq_push) begin
            r_pan_now  <= n_result.pan;
            r_tilt_now <= n_result.tilt;
            r_laser    <= n_result.laser;
        end
    end

    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_owp] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (oq_push) begin
                r_owp <= ~r_owp;
            end
            if (i_pop && !o_empty) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(oq_push) - 2'(i_pop && !o_empty);
        end
    end

endmodule
`default_nettype wire

[rtl/pan_tilt_target_follower_top.sv]
// Top level of the pan/tilt target follower with its configuration registers.
// The shared 36-step divider runs twice for a lost or a locked frame and for a moving one
// with equal or crossed pan limits, and three times for any other moving frame. The back end
// takes a new frame only once the result of the last one is queued, and a result waits while
// the result queue is full.
// Two frames and two results can be queued. Reset is synchronous and active low; it restores
// the register defaults, centres pan and tilt with the laser off, and the block is ready at once.
`timescale 1ns / 1ps
`default_nettype none
module pan_tilt_target_follower_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    output logic                          o_full,
    input  wire  [ptf_pkg::SumW-1:0]      i_sum_x,
    input  wire  [ptf_pkg::SumW-1:0]      i_sum_y,
    input  wire  [ptf_pkg::WgtW-1:0]      i_pixel_weight,
    input  wire  [ptf_pkg::AreaW-1:0]     i_blob_area,
    output logic                          o_empty,
    input  wire                           i_pop,
    output logic [ptf_pkg::PosW-1:0]      o_pan_position,
    output logic [ptf_pkg::PosW-1:0]      o_tilt_position,
    output logic                          o_laser_on,
    output logic [1:0]                    o_status,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [ptf_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire  [ptf_pkg::CfgDataW-1:0]  i_cfg_data
);
    import ptf_pkg::*;

    t_cfg     r_cfg;
    logic     fr_valid;
    t_item    fr_item;
    logic     bk_take;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_result  result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pan_min   <= PanMinRst;
            r_cfg.pan_max   <= PanMaxRst;
            r_cfg.tilt_min  <= TiltMinRst;
            r_cfg.tilt_max  <= TiltMaxRst;
            r_cfg.target_x  <= TargXRst;
            r_cfg.target_y  <= TargYRst;
            r_cfg.step_gain <= GainRst;
            r_cfg.area_min  <= AreaMinRst;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PAN_MIN:   r_cfg.pan_min   <= i_cfg_data[PosW-1:0];
                CFG_PAN_MAX:   r_cfg.pan_max   <= i_cfg_data[PosW-1:0];
                CFG_TILT_MIN:  r_cfg.tilt_min  <= i_cfg_data[PosW-1:0];
                CFG_TILT_MAX:  r_cfg.tilt_max  <= i_cfg_data[PosW-1:0];
                CFG_TARGET_X:  r_cfg.target_x  <= i_cfg_data[PosW-1:0];
                CFG_TARGET_Y:  r_cfg.target_y  <= i_cfg_data[PosW-1:0];
                CFG_STEP_GAIN: r_cfg.step_gain <= i_cfg_data[PosW-1:0];
                CFG_AREA_MIN:  r_cfg.area_min  <= i_cfg_data[AreaW-1:0];
                default:       r_cfg.area_min  <= r_cfg.area_min;
            endcase
        end
    end

    ptf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_sum_x        (i_sum_x),
        .i_sum_y        (i_sum_y),
        .i_pixel_weight (i_pixel_weight),
        .i_blob_area    (i_blob_area),
        .i_area_min     (r_cfg.area_min),
        .o_valid        (fr_valid),
        .o_item         (fr_item),
        .i_take         (bk_take)
    );

    ptf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ptf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (fr_valid),
        .i_item    (fr_item),
        .o_take    (bk_take),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (result)
    );

    assign o_pan_position  = result.pan;
    assign o_tilt_position = result.tilt;
    assign o_laser_on      = result.laser;
    assign o_status        = result.status;

endmodule
`default_nettype wire
